// File: src/ledseq_pkg.sv
// Shared types and constants for the multichannel LED sequencer.
`timescale 1ns / 1ps

package ledseq_pkg;

    localparam int CHANNELS   = 20;
    localparam int TIME_BITS  = 32;
    localparam int CH_IDX_W   = $clog2(CHANNELS);
    localparam int OPCODE_W   = 3;
    localparam int CHANNEL_W  = 5;
    localparam int TV_W       = 32;
    localparam int LEVELS_W   = 20;
    localparam int PAT_LIT_MS = 100;
    localparam int PAT_DARK_MS = 50;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK    = 3'd0,
        OP_ON      = 3'd1,
        OP_OFF     = 3'd2,
        OP_BLINK   = 3'd3,
        OP_ONESHOT = 3'd4,
        OP_PATTERN = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_BLINK   = 2'd1,
        MODE_ONESHOT = 2'd2,
        MODE_PATTERN = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PH_LIT1   = 2'd0,
        PH_DARK   = 2'd1,
        PH_LIT2   = 2'd2,
        PH_FINISH = 2'd3
    } phase_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] mark_time;
        logic [TIME_BITS-1:0] period;
        mode_t                mode;
        phase_t               phase;
    } chan_entry_t;

    typedef struct packed {
        logic                wr_en;
        logic [CH_IDX_W-1:0] wr_addr;
        logic                rd_en;
        logic [CH_IDX_W-1:0] rd_addr;
    } ram_ctrl_t;

endpackage

// File: src/ledseq_state_ram.sv
// Per-channel state memory with registered read data and reset valid bits.
`timescale 1ns / 1ps

module ledseq_state_ram (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ledseq_pkg::ram_ctrl_t  ctrl,
    input  ledseq_pkg::chan_entry_t wr_data,
    output ledseq_pkg::chan_entry_t rd_data
);
    import ledseq_pkg::*;

    chan_entry_t           mem_reg [CHANNELS];
    logic [CHANNELS-1:0]   valid_reg;
    chan_entry_t           rd_data_reg;
    logic                  rd_hit_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem_reg[ctrl.wr_addr] <= wr_data;
        end
        if (ctrl.rd_en) begin
            rd_data_reg <= mem_reg[ctrl.rd_addr];
        end
    end

    // Entries never written since reset read as all zero (idle channel).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end else begin
            if (ctrl.wr_en) begin
                valid_reg[ctrl.wr_addr] <= 1'b1;
            end
            if (ctrl.rd_en) begin
                rd_hit_reg <= valid_reg[ctrl.rd_addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

// File: src/ledseq_chan_update.sv
// Next-state logic of one channel for a tick or a command.
`timescale 1ns / 1ps

module ledseq_chan_update (
    input  ledseq_pkg::op_t                    op,
    input  logic [ledseq_pkg::TIME_BITS-1:0]   time_now,
    input  logic [ledseq_pkg::TIME_BITS-1:0]   time_value,
    input  ledseq_pkg::chan_entry_t            entry_in,
    input  logic                               level_in,
    output ledseq_pkg::chan_entry_t            entry_out,
    output logic                               level_out
);
    import ledseq_pkg::*;

    logic [TIME_BITS-1:0] elapsed;
    logic                 period_due;
    logic                 lit_due;
    logic                 dark_due;

    // Wrapping subtraction gives the age of the last recorded event.
    assign elapsed    = time_now - entry_in.mark_time;
    assign period_due = elapsed >= entry_in.period;
    assign lit_due    = elapsed >= TIME_BITS'(PAT_LIT_MS);
    assign dark_due   = elapsed >= TIME_BITS'(PAT_DARK_MS);

    always_comb begin
        entry_out = entry_in;
        level_out = level_in;
        unique case (op)
            OP_TICK: begin
                unique case (entry_in.mode)
                    MODE_BLINK: begin
                        if (period_due) begin
                            level_out           = ~level_in;
                            entry_out.mark_time = time_now;
                        end
                    end
                    MODE_ONESHOT: begin
                        if (period_due) begin
                            level_out      = 1'b0;
                            entry_out.mode = MODE_IDLE;
                        end
                    end
                    MODE_PATTERN: begin
                        unique case (entry_in.phase)
                            PH_LIT1: begin
                                if (lit_due) begin
                                    level_out           = 1'b0;
                                    entry_out.phase     = PH_DARK;
                                    entry_out.mark_time = time_now;
                                end
                            end
                            PH_DARK: begin
                                if (dark_due) begin
                                    level_out           = 1'b1;
                                    entry_out.phase     = PH_LIT2;
                                    entry_out.mark_time = time_now;
                                end
                            end
                            PH_LIT2: begin
                                if (lit_due) begin
                                    level_out           = 1'b0;
                                    entry_out.phase     = PH_FINISH;
                                    entry_out.mark_time = time_now;
                                end
                            end
                            default: begin
                                entry_out.mode = MODE_IDLE;
                            end
                        endcase
                    end
                    default: begin
                    end
                endcase
            end
            OP_ON: begin
                entry_out.mode = MODE_IDLE;
                level_out      = 1'b1;
            end
            OP_OFF: begin
                entry_out.mode = MODE_IDLE;
                level_out      = 1'b0;
            end
            OP_BLINK: begin
                entry_out.mode      = MODE_BLINK;
                entry_out.period    = time_value;
                entry_out.mark_time = time_now;
            end
            OP_ONESHOT: begin
                entry_out.mode      = MODE_ONESHOT;
                entry_out.period    = time_value;
                entry_out.mark_time = time_now;
                level_out           = 1'b1;
            end
            OP_PATTERN: begin
                entry_out.mode      = MODE_PATTERN;
                entry_out.phase     = PH_LIT1;
                entry_out.mark_time = time_now;
                level_out           = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: src/multichannel_led_sequencer.sv
// Top level of the multichannel LED sequencer: control, time base, levels, result word.
`timescale 1ns / 1ps

// Usage
//   Input channel (s_valid/s_ready): one word per item. s_opcode 0 is a
//   one-millisecond tick; 1..5 are on, off, blink, one-shot and pattern
//   commands for channel s_channel, with s_time_value as blink period or
//   one-shot duration. Opcodes 6 and 7 change nothing.
//   Result channel (m_valid/m_ready): exactly one word per input word,
//   m_status (1 = channel out of range) and m_led_levels (bit per channel).
//   Sequence: a tick walks all 20 channel entries of the state memory, one
//   read-modify-write per cycle, then loads the result; a command reads,
//   updates and writes back one entry; an ignored word goes straight to the
//   result. The single read and single write port of the state memory set
//   this pace.
//   Throughput: one item in flight; the next word can be taken in the cycle
//   after the result is loaded.
//   Stall: a finished result goes to the output register; if that register
//   is full and m_ready is low, the block holds the result and takes no input.
//   Reset: synchronous, active low; time, levels and all channel entries
//   read as zero (idle, off) afterward, with no clearing pass.
module multichannel_led_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ledseq_pkg::OPCODE_W-1:0]     s_opcode,
    input  logic [ledseq_pkg::CHANNEL_W-1:0]    s_channel,
    input  logic [ledseq_pkg::TV_W-1:0]         s_time_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_status,
    output logic [ledseq_pkg::LEVELS_W-1:0]     m_led_levels
);
    import ledseq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMD  = 4'b0010,
        S_TICK = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [CH_IDX_W-1:0]  idx_reg, idx_next;
    logic [TIME_BITS-1:0] tv_reg, tv_next;
    logic                 status_reg, status_next;
    logic [TIME_BITS-1:0] time_now_reg, time_now_next;
    logic [CHANNELS-1:0]  level_reg, level_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_status_reg;
    logic [LEVELS_W-1:0]  m_levels_reg;

    ram_ctrl_t            ram_ctrl;
    chan_entry_t          rd_entry;
    chan_entry_t          wr_entry;
    logic                 level_upd;

    logic                 s_fire;
    logic                 in_is_tick;
    logic                 in_is_cmd;
    logic                 in_bad_ch;
    logic                 out_load;
    logic [LEVELS_W-1:0]  levels_word;

    ledseq_state_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ram_ctrl),
        .wr_data (wr_entry),
        .rd_data (rd_entry)
    );

    // Read data for channel idx_reg arrives this cycle; update and write back.
    ledseq_chan_update u_upd (
        .op         (op_reg),
        .time_now   (time_now_reg),
        .time_value (tv_reg),
        .entry_in   (rd_entry),
        .level_in   (level_reg[idx_reg]),
        .entry_out  (wr_entry),
        .level_out  (level_upd)
    );

    assign s_ready    = (state_reg == S_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign in_is_tick = (s_opcode == OP_TICK);
    assign in_is_cmd  = (s_opcode >= OP_ON) && (s_opcode <= OP_PATTERN);
    assign in_bad_ch  = (32'(s_channel) >= CHANNELS);
    assign out_load   = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    // Only channels below the level word width show up in the result.
    always_comb begin
        levels_word = '0;
        for (int i = 0; i < LEVELS_W; i++) begin
            if (i < CHANNELS) begin
                levels_word[i] = level_reg[i];
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        tv_next       = tv_reg;
        status_next   = status_reg;
        time_now_next = time_now_reg;
        level_next    = level_reg;
        ram_ctrl      = '0;
        ram_ctrl.wr_addr = idx_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    op_next     = op_t'(s_opcode);
                    tv_next     = TIME_BITS'(s_time_value);
                    status_next = 1'b0;
                    if (in_is_tick) begin
                        // Advance time first, then walk every channel from 0.
                        time_now_next    = time_now_reg + 1'b1;
                        idx_next         = '0;
                        ram_ctrl.rd_en   = 1'b1;
                        ram_ctrl.rd_addr = '0;
                        state_next       = S_TICK;
                    end else if (in_is_cmd && !in_bad_ch) begin
                        idx_next         = CH_IDX_W'(s_channel);
                        ram_ctrl.rd_en   = 1'b1;
                        ram_ctrl.rd_addr = CH_IDX_W'(s_channel);
                        state_next       = S_CMD;
                    end else begin
                        // Drop: rejected channel or unused opcode.
                        status_next = in_is_cmd;
                        state_next  = S_DONE;
                    end
                end
            end
            S_CMD: begin
                ram_ctrl.wr_en      = 1'b1;
                level_next[idx_reg] = level_upd;
                state_next          = S_DONE;
            end
            S_TICK: begin
                // Write back this channel while reading the next one.
                ram_ctrl.wr_en      = 1'b1;
                level_next[idx_reg] = level_upd;
                if (idx_reg == CH_IDX_W'(CHANNELS - 1)) begin
                    state_next = S_DONE;
                end else begin
                    idx_next         = idx_reg + 1'b1;
                    ram_ctrl.rd_en   = 1'b1;
                    ram_ctrl.rd_addr = idx_reg + 1'b1;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            time_now_reg <= '0;
            level_reg    <= '0;
            m_valid_reg  <= 1'b0;
            status_reg   <= 1'b0;
            idx_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            time_now_reg <= time_now_next;
            level_reg    <= level_next;
            m_valid_reg  <= m_valid_next;
            status_reg   <= status_next;
            idx_reg      <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg <= op_next;
        tv_reg <= tv_next;
        if (out_load) begin
            m_status_reg <= status_reg;
            m_levels_reg <= levels_word;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_led_levels = m_levels_reg;

    // The sweep never reads the entry it is writing back.
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_ctrl.wr_en && ram_ctrl.rd_en) |-> (ram_ctrl.wr_addr != ram_ctrl.rd_addr))
        else $error("state memory read and write hit the same channel");

    // Time moves only when a tick is taken.
    a_time_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_fire && in_is_tick) |=> $stable(time_now_reg))
        else $error("time counter moved without a tick");

    // Levels change only while a channel entry is being written back.
    a_level_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !ram_ctrl.wr_en |=> $stable(level_reg))
        else $error("levels changed outside a write-back");

    // A result is loaded only into a free or draining output register.
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready && state_reg == S_DONE) |=> (state_reg == S_DONE))
        else $error("finished result left while output was stalled");

endmodule
